// ----- sv/saa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the stack arena allocator.
package saa_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 17;
	localparam int ALIGN_W   = 4;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int MASK_W    = 13;

	localparam logic [ALIGN_W-1:0] ALIGN_MAX  = 4'd12;
	localparam logic [ALIGN_W-1:0] PUSH_LOG2  = 4'd3;
	localparam logic [SIZE_W-1:0]  PUSH_BYTES = 17'd8;
	localparam logic [ADDR_W:0]    ADDR_LIMIT = {1'b1, {ADDR_W{1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_ARENA_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ARENA_SIZE = 1'b1;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_PUSH  = 2'd1,
		ACT_POP   = 2'd2,
		ACT_RESET = 2'd3
	} saa_action_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NULL   = 3'd1,
		ST_OOM    = 3'd2,
		ST_BOTTOM = 3'd3,
		ST_FULL   = 3'd4
	} saa_status_t;

	typedef struct packed {
		saa_action_t        action;
		logic [SIZE_W-1:0]  alloc_size;
		logic [ALIGN_W-1:0] align_log2;
	} saa_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		saa_status_t       status;
	} saa_result_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} saa_stk_ctl_t;

endpackage

// ----- sv/saa_frame_stack.sv -----
`timescale 1ns / 1ps
// LIFO store of saved frame bases with a registered top-of-stack word.
module saa_frame_stack #(
	parameter int MAX_FRAMES = 64,
	parameter int DEPTH_W    = $clog2(MAX_FRAMES + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  saa_pkg::saa_stk_ctl_t        ctl,
	input  logic [saa_pkg::ADDR_W-1:0]   push_data,
	output logic [DEPTH_W-1:0]           depth,
	output logic [saa_pkg::ADDR_W-1:0]   top
);
	import saa_pkg::*;

	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	logic [ADDR_W-1:0]  mem [MAX_FRAMES];
	logic [ADDR_W-1:0]  top_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] depth_d;
	logic [DEPTH_W-1:0] below_d;
	logic [AW-1:0]      wr_idx;
	logic [AW-1:0]      rd_idx;

	always_comb begin
		if (ctl.clear) begin
			depth_d = '0;
		end else if (ctl.push) begin
			depth_d = depth_q + DEPTH_W'(1);
		end else if (ctl.pop) begin
			depth_d = depth_q - DEPTH_W'(1);
		end else begin
			depth_d = depth_q;
		end
	end

	// top word always tracks entry depth-1 of the new depth
	assign below_d = depth_d - DEPTH_W'(1);
	assign rd_idx  = below_d[AW-1:0];
	assign wr_idx  = depth_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_idx] <= push_data;
		end
		top_q <= ctl.push ? push_data : mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_d;
		end
	end

	assign depth = depth_q;
	assign top   = top_q;

endmodule

// ----- sv/saa_core.sv -----
`timescale 1ns / 1ps
// Pointer registers and the combinational allocate / push / pop / reset logic.
module saa_core #(
	parameter int MAX_FRAMES = 64,
	parameter int DEPTH_W    = $clog2(MAX_FRAMES + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_clear,
	input  logic [saa_pkg::ADDR_W-1:0]   clear_base,
	input  logic [saa_pkg::ADDR_W-1:0]   arena_base,
	input  logic [saa_pkg::ADDR_W:0]     arena_end,
	input  logic                         cmd_valid,
	input  saa_pkg::saa_cmd_t            cmd,
	input  logic [DEPTH_W-1:0]           depth,
	input  logic [saa_pkg::ADDR_W-1:0]   top,
	output saa_pkg::saa_stk_ctl_t        stk_ctl,
	output logic [saa_pkg::ADDR_W-1:0]   push_data,
	output saa_pkg::saa_result_t         result
);
	import saa_pkg::*;

	logic [ADDR_W-1:0]  next_free_q;
	logic [ADDR_W-1:0]  frame_base_q;

	logic               is_push;
	logic [ALIGN_W-1:0] lg;
	logic [SIZE_W-1:0]  req;
	logic [MASK_W-1:0]  mask;
	logic [ADDR_W:0]    at;
	logic [ADDR_W+1:0]  end_addr;
	logic               fits;
	logic               full;
	logic               bottom;

	logic               upd_ptrs;
	logic [ADDR_W-1:0]  next_free_d;
	logic [ADDR_W-1:0]  frame_base_d;
	logic               act_clear;

	// shared align + bump unit: push is an 8-byte, 8-aligned reserve
	assign is_push = (cmd.action == ACT_PUSH);
	assign lg      = is_push ? PUSH_LOG2 :
	                 ((cmd.align_log2 > ALIGN_MAX) ? ALIGN_MAX : cmd.align_log2);
	assign req     = is_push ? PUSH_BYTES : cmd.alloc_size;
	assign mask    = ~({MASK_W{1'b1}} << lg);
	assign at      = ({1'b0, next_free_q} + (ADDR_W + 1)'(mask))
	                 & ~((ADDR_W + 1)'(mask));
	assign end_addr = {1'b0, at} + (ADDR_W + 2)'(req);
	assign fits     = (end_addr <= {1'b0, arena_end});

	assign full   = (depth >= DEPTH_W'(MAX_FRAMES));
	assign bottom = (frame_base_q <= arena_base) || (depth == '0);

	always_comb begin
		result.address = '0;
		result.status  = ST_OK;
		upd_ptrs       = 1'b0;
		next_free_d    = next_free_q;
		frame_base_d   = frame_base_q;
		act_clear      = 1'b0;
		stk_ctl.push   = 1'b0;
		stk_ctl.pop    = 1'b0;
		case (cmd.action)
			ACT_ALLOC: begin
				if (cmd.alloc_size == '0) begin
					result.status = ST_NULL;
				end else if (!fits) begin
					result.status = ST_OOM;
				end else begin
					upd_ptrs       = 1'b1;
					next_free_d    = end_addr[ADDR_W-1:0];
					result.address = at[ADDR_W-1:0];
				end
			end
			ACT_PUSH: begin
				if (full) begin
					result.status = ST_FULL;
				end else if (!fits) begin
					result.status = ST_OOM;
				end else begin
					upd_ptrs       = 1'b1;
					stk_ctl.push   = cmd_valid;
					next_free_d    = end_addr[ADDR_W-1:0];
					frame_base_d   = end_addr[ADDR_W-1:0];
					result.address = end_addr[ADDR_W-1:0];
				end
			end
			ACT_POP: begin
				if (bottom) begin
					result.status = ST_BOTTOM;
				end else begin
					upd_ptrs       = 1'b1;
					stk_ctl.pop    = cmd_valid;
					next_free_d    = frame_base_q;
					frame_base_d   = top;
					result.address = top;
				end
			end
			ACT_RESET: begin
				act_clear      = 1'b1;
				result.address = arena_base;
			end
			default: begin
				result.status = ST_OK;
			end
		endcase
		stk_ctl.clear = cfg_clear || (cmd_valid && act_clear);
	end

	assign push_data = frame_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q  <= '0;
			frame_base_q <= '0;
		end else if (cfg_clear) begin
			next_free_q  <= clear_base;
			frame_base_q <= clear_base;
		end else if (cmd_valid && act_clear) begin
			next_free_q  <= arena_base;
			frame_base_q <= arena_base;
		end else if (cmd_valid && upd_ptrs) begin
			next_free_q  <= next_free_d;
			frame_base_q <= frame_base_d;
		end
	end

endmodule

// ----- sv/stack_arena_allocator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the stack arena allocator: config, input and result registers.
//
// Usage:
//  - Command channel: a word on cmd is taken at each clock edge where start is
//    high and busy is low. busy never rises, so a word can be issued every
//    cycle: one action per cycle sustained.
//  - Result channel: done is high for exactly one cycle with the matching word
//    on result. Each command yields one result, in issue order: the accepted
//    word passes the input register, then the result register, and done rises
//    as the result register takes it.
//  - The receiver cannot stall; a result not captured in its done cycle is gone.
//  - Config port: cfg_we/cfg_idx/cfg_wdata write arena_base (index 0) or
//    arena_size (index 1). Any write also empties the arena: next-free and
//    frame base go to the new base and the frame store empties.
//    Write only while no command is in flight.
//  - Each command depends on the pointers left by the one before; the
//    align/add/compare path and the frame-store top register settle between
//    the input and result registers.
//  - Reset (arst_n low): base 0, size MAX_ARENA_BYTES, arena empty, no result
//    pending. The frame store contents are not cleared; only entries below the
//    current depth are ever used.
module stack_arena_allocator_unit #(
	parameter int MAX_FRAMES      = 64,
	parameter int MAX_ARENA_BYTES = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  saa_pkg::saa_cmd_t               cmd,
	output logic                            done,
	output saa_pkg::saa_result_t            result,
	input  logic                            cfg_we,
	input  logic [saa_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [saa_pkg::CFG_W-1:0]       cfg_wdata
);
	import saa_pkg::*;

	localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);
	// size register must hold the reset value as well as any saturated write
	localparam int SZ_RAW  = $clog2(MAX_ARENA_BYTES + 1);
	localparam int SZW     = (SZ_RAW > SIZE_W) ? SZ_RAW : SIZE_W;

	// config registers
	logic [ADDR_W-1:0] base_q;
	logic [SZW-1:0]    size_q;
	logic [ADDR_W:0]   end_q;

	logic [SZW-1:0]    wsize;
	logic [ADDR_W-1:0] new_base;
	logic [SZW-1:0]    new_size;
	logic [ADDR_W:0]   end_sum;
	logic [ADDR_W:0]   new_end;

	// pipeline
	logic              valid_s1;
	saa_cmd_t          cmd_s1;
	logic              done_s2;
	saa_result_t       result_s2;

	saa_result_t       core_result;
	saa_stk_ctl_t      stk_ctl;
	logic [ADDR_W-1:0] push_data;
	logic [DEPTH_W-1:0] depth;
	logic [ADDR_W-1:0] top;

	// config write: saturate size, recompute the (saturated) arena end
	assign wsize = SZW'(cfg_wdata[SIZE_W-1:0]);

	always_comb begin
		new_base = base_q;
		new_size = size_q;
		case (cfg_idx)
			REG_ARENA_BASE: begin
				new_base = cfg_wdata[ADDR_W-1:0];
			end
			REG_ARENA_SIZE: begin
				new_size = (wsize > SZW'(MAX_ARENA_BYTES)) ? SZW'(MAX_ARENA_BYTES) : wsize;
			end
			default: begin
				new_base = base_q;
			end
		endcase
		end_sum = {1'b0, new_base} + (ADDR_W + 1)'(new_size);
		new_end = (end_sum > ADDR_LIMIT) ? ADDR_LIMIT : end_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= SZW'(MAX_ARENA_BYTES);
			end_q  <= (ADDR_W + 1)'(MAX_ARENA_BYTES);
		end else if (cfg_we) begin
			base_q <= new_base;
			size_q <= new_size;
			end_q  <= new_end;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	saa_core #(
		.MAX_FRAMES (MAX_FRAMES),
		.DEPTH_W    (DEPTH_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_clear  (cfg_we),
		.clear_base (new_base),
		.arena_base (base_q),
		.arena_end  (end_q),
		.cmd_valid  (valid_s1),
		.cmd        (cmd_s1),
		.depth      (depth),
		.top        (top),
		.stk_ctl    (stk_ctl),
		.push_data  (push_data),
		.result     (core_result)
	);

	saa_frame_stack #(
		.MAX_FRAMES (MAX_FRAMES),
		.DEPTH_W    (DEPTH_W)
	) u_frame_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.push_data (push_data),
		.depth     (depth),
		.top       (top)
	);

	// result register: one-cycle strobe, no back-pressure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= core_result;
		end
	end

	assign busy   = 1'b0;
	assign done   = done_s2;
	assign result = result_s2;

endmodule

// ----- dv/saa_arena_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the stack arena allocator: mirrors the arena and checks each result word.
module saa_arena_checker #(
	parameter int MAX_FRAMES      = 64,
	parameter int MAX_ARENA_BYTES = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  saa_pkg::saa_cmd_t             cmd,
	input  logic                          done,
	input  saa_pkg::saa_result_t          result,
	input  logic                          cfg_we,
	input  logic [saa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [saa_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            fail_count,
	output int                            awaited
);
	import saa_pkg::*;

	localparam int                  IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam logic [SIZE_W-1:0]   ARENA_CAP = SIZE_W'(MAX_ARENA_BYTES);
	localparam logic [ADDR_W+1:0]   WIDE_ONE  = (ADDR_W + 2)'(1);

	logic [ADDR_W-1:0] arena_base;
	logic [SIZE_W-1:0] arena_len;
	logic [ADDR_W-1:0] next_free;
	logic [ADDR_W-1:0] frame_base;
	logic [ADDR_W-1:0] saved_bases [MAX_FRAMES];
	int                frame_depth;
	int                errors = 0;
	saa_result_t       owed_replies [$];
	saa_result_t       want;

	task automatic empty_arena();
		next_free   = arena_base;
		frame_base  = arena_base;
		frame_depth = 0;
	endtask

	// end address, clipped at the top of the address space
	function automatic logic [ADDR_W:0] arena_limit();
		logic [ADDR_W+1:0] e;
		e = {2'b00, arena_base} + (ADDR_W + 2)'(arena_len);
		return (e > {1'b0, ADDR_LIMIT}) ? ADDR_LIMIT : e[ADDR_W:0];
	endfunction

	// align next_free up, add len; true when it fits below the end
	function automatic logic carve(input logic [SIZE_W-1:0] len, input logic [ALIGN_W-1:0] lg,
			output logic [ADDR_W-1:0] at, output logic [ADDR_W-1:0] after);
		logic [ADDR_W+1:0] mask;
		logic [ADDR_W+1:0] lo;
		logic [ADDR_W+1:0] hi;
		mask  = (WIDE_ONE << lg) - WIDE_ONE;
		lo    = ({2'b00, next_free} + mask) & ~mask;
		hi    = lo + (ADDR_W + 2)'(len);
		at    = lo[ADDR_W-1:0];
		after = hi[ADDR_W-1:0];
		return hi <= {1'b0, arena_limit()};
	endfunction

	task automatic apply_arena_action(input saa_cmd_t c, output saa_result_t r);
		logic [ALIGN_W-1:0] lg;
		logic [ADDR_W-1:0]  at;
		logic [ADDR_W-1:0]  after;
		logic               fits;
		lg        = (c.align_log2 > ALIGN_MAX) ? ALIGN_MAX : c.align_log2;
		r.address = '0;
		r.status  = ST_OK;
		case (c.action)
			ACT_ALLOC: begin
				fits = carve(c.alloc_size, lg, at, after);
				if (c.alloc_size == '0) begin
					r.status = ST_NULL;
				end else if (!fits) begin
					r.status = ST_OOM;
				end else begin
					next_free = after;
					r.address = at;
				end
			end
			ACT_PUSH: begin
				fits = carve(PUSH_BYTES, PUSH_LOG2, at, after);
				if (frame_depth >= MAX_FRAMES) begin
					r.status = ST_FULL;
				end else if (!fits) begin
					r.status = ST_OOM;
				end else begin
					saved_bases[IDX_W'(frame_depth)] = frame_base;
					frame_depth++;
					next_free  = after;
					frame_base = after;
					r.address  = after;
				end
			end
			ACT_POP: begin
				if (frame_base <= arena_base || frame_depth == 0) begin
					r.status = ST_BOTTOM;
				end else begin
					next_free = frame_base;
					frame_depth--;
					frame_base = saved_bases[IDX_W'(frame_depth)];
					r.address  = frame_base;
				end
			end
			ACT_RESET: begin
				empty_arena();
				r.address = arena_base;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_base = '0;
			arena_len  = ARENA_CAP;
			empty_arena();
			owed_replies.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_ARENA_BASE) begin
					arena_base = cfg_wdata;
				end else begin
					arena_len = (cfg_wdata[SIZE_W-1:0] > ARENA_CAP) ? ARENA_CAP
						: cfg_wdata[SIZE_W-1:0];
				end
				empty_arena();
			end
			if (done) begin
				if (owed_replies.size() == 0) begin
					errors++;
					$display("%0t: result with none pending: address %h status %0d",
						$time, result.address, result.status);
				end else begin
					want = owed_replies.pop_front();
					if (result.address !== want.address) begin
						errors++;
						$display("%0t: address expected %h actual %h",
							$time, want.address, result.address);
					end
					if (result.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
					end
				end
			end
			if (start && !busy) begin
				apply_arena_action(cmd, want);
				owed_replies.push_back(want);
			end
		end
		fail_count <= errors;
		awaited    <= owed_replies.size();
	end

endmodule

// ----- dv/stack_arena_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the stack arena allocator: stimulus phases and verdict.
module stack_arena_allocator_unit_tb;
	import saa_pkg::*;

	localparam int MAX_FRAMES      = 64;
	localparam int MAX_ARENA_BYTES = 65536;
	localparam int CLK_PERIOD      = 20;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	saa_cmd_t             cmd;
	logic                 done;
	saa_result_t          result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	int fail_count;
	int awaited;
	// words left in the current back-to-back stretch
	int calm_left;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// hard stop; a clean run needs well under a tenth of this
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	stack_arena_allocator_unit #(
		.MAX_FRAMES     (MAX_FRAMES),
		.MAX_ARENA_BYTES(MAX_ARENA_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	saa_arena_checker #(
		.MAX_FRAMES     (MAX_FRAMES),
		.MAX_ARENA_BYTES(MAX_ARENA_BYTES)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.awaited   (awaited)
	);

	// Issue one command word, after an idle gap of random length except inside a
	// back-to-back stretch. start stays high across consecutive words with no
	// gap so it is never dropped and raised in the same step.
	task automatic send_word(input saa_action_t a, input logic [SIZE_W-1:0] sz,
			input logic [ALIGN_W-1:0] lg);
		int       gap;
		saa_cmd_t w;
		if (calm_left > 0) begin
			gap = 0;
			calm_left--;
		end else if ($urandom_range(0, 19) == 0) begin
			gap = 0;
			calm_left = $urandom_range(20, 60);
		end else begin
			gap = $urandom_range(0, 10);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.action     = a;
		w.alloc_size = sz;
		w.align_log2 = lg;
		start <= 1'b1;
		cmd   <= w;
		// busy is read right after the edge, i.e. the value the block saw
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Run of one action with junk in the ignored fields: push runs walk the
	// frame store toward full, pop runs unwind it back to the bottom.
	task automatic repeat_action(input saa_action_t a, input int n);
		repeat (n) send_word(a, SIZE_W'($urandom_range(0, 65536)),
			ALIGN_W'($urandom_range(0, 15)));
	endtask

	// Small and mid-size allocations mixed with pushes, pops and resets so frames
	// nest; a few huge sizes, zero sizes, alignments past twelve and raw noise.
	task automatic random_word();
		int                 pick;
		saa_action_t        act;
		logic [SIZE_W-1:0]  sz;
		logic [ALIGN_W-1:0] lg;
		pick = $urandom_range(0, 99);
		act  = ACT_ALLOC;
		sz   = SIZE_W'($urandom_range(0, 65536));
		lg   = ALIGN_W'($urandom_range(0, 15));
		if (pick < 35) begin
			sz = SIZE_W'($urandom_range(1, 64));
			lg = ALIGN_W'($urandom_range(0, 4));
		end else if (pick < 45) begin
			sz = SIZE_W'($urandom_range(1, 4096));
			lg = ALIGN_W'($urandom_range(0, 12));
		end else if (pick < 48) begin
			sz = SIZE_W'($urandom_range(1, 65536));
		end else if (pick < 50) begin
			sz = '0;
		end else if (pick < 71) begin
			act = ACT_PUSH;
		end else if (pick < 91) begin
			act = ACT_POP;
		end else if (pick < 94) begin
			act = ACT_RESET;
		end else begin
			act = saa_action_t'(2'($urandom_range(0, 3)));
		end
		send_word(act, sz, lg);
	endtask

	task automatic run_random(input int n);
		int k;
		int pick;
		int len;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(0, 99);
			if (pick == 0) begin
				len = $urandom_range(60, 70);
				repeat_action(ACT_PUSH, len);
				k += len;
			end else if (pick == 1) begin
				len = $urandom_range(60, 70);
				repeat_action(ACT_POP, len);
				k += len;
			end else begin
				random_word();
				k++;
			end
		end
	endtask

	// Stop issuing and wait until every result word has come back. Every
	// command yields a word, so an empty scoreboard means the pipe is empty.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers, back to back, only once the block is idle.
	task automatic program_arena(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] len);
		drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_ARENA_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_idx   <= REG_ARENA_SIZE;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_ARENA_BASE;
		cfg_wdata <= '0;
		calm_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset arena: base 0, full 64 KiB ---
		send_word(ACT_POP, 17'd0, 4'd0);          // empty store: pop at bottom
		send_word(ACT_ALLOC, 17'd0, 4'd0);        // zero size: null
		send_word(ACT_ALLOC, 17'd1, 4'd0);
		send_word(ACT_ALLOC, 17'd3, 4'd12);       // widest alignment
		send_word(ACT_ALLOC, 17'd5, 4'd15);       // alignment clipped to twelve
		send_word(ACT_ALLOC, 17'd65536, 4'd0);    // past the end: out of memory
		send_word(ACT_PUSH, 17'h1ffff, 4'hf);
		send_word(ACT_ALLOC, 17'd7, 4'd2);
		send_word(ACT_PUSH, 17'd0, 4'd0);
		send_word(ACT_POP, 17'd0, 4'd0);
		send_word(ACT_POP, 17'd0, 4'd0);
		send_word(ACT_POP, 17'd0, 4'd0);          // back at the bottom
		send_word(ACT_RESET, 17'd0, 4'd0);
		send_word(ACT_ALLOC, 17'd65536, 4'd0);    // exact fit of the whole arena
		send_word(ACT_ALLOC, 17'd1, 4'd0);        // nothing left
		send_word(ACT_PUSH, 17'd0, 4'd0);         // push without space
		send_word(ACT_POP, 17'd0, 4'd0);
		send_word(ACT_RESET, 17'h1ffff, 4'hf);
		run_random(150);

		// --- arena ends exactly at the top of the address space; a push
		// wraps next-free and frame base to zero, so pop sees a base not
		// above the arena base while the store is not empty ---
		program_arena(32'hffff_fff8, 32'd8);
		send_word(ACT_PUSH, 17'd0, 4'd0);
		send_word(ACT_POP, 17'd0, 4'd0);
		send_word(ACT_ALLOC, 17'd1, 4'd0);
		send_word(ACT_PUSH, 17'd0, 4'd0);
		run_random(30);

		// --- odd base, oversized length word clips to the maximum ---
		program_arena(32'h1234_5673, 32'hffff_ffff);
		run_random(120);

		// --- empty arena: every nonzero allocate and every push runs out of memory ---
		program_arena(32'h0000_0000, 32'd0);
		run_random(30);

		// --- highest base; end clipped at the address-space limit ---
		program_arena(32'hffff_ffff, 32'd65536);
		run_random(50);

		// --- one-byte arena at a random base ---
		program_arena($urandom(), 32'd1);
		run_random(30);

		// --- small arena, out of memory comes often ---
		program_arena($urandom(), $urandom_range(64, 2048));
		run_random(150);

		// --- full-size arena ending exactly at the top ---
		program_arena(32'hffff_0000, 32'd65536);
		run_random(100);

		// --- random base and length ---
		program_arena($urandom(), $urandom_range(1, 65536));
		run_random(90);

		drain();
		if (fail_count == 0 && awaited == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/saa_pkg.sv
sv/saa_frame_stack.sv
sv/saa_core.sv
sv/stack_arena_allocator_unit.sv
dv/saa_arena_checker.sv
dv/stack_arena_allocator_unit_tb.sv
